// File: rtl/rsd_pkg.sv
// shared types and constants for the rounded signed divider
package rsd_pkg;

    // stages outside the one-bit-per-stage divide: magnitudes, rounding, sign and saturation
    localparam int PIPE_EXTRA = 3;

    typedef struct packed {
        logic neg;
        logic dz;
    } rsd_flag_t;

endpackage

// File: rtl/rsd_if.sv
// valid/ready channel interfaces for operand and result beats
interface rsd_op_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] dividend;
    logic signed [DATA_WIDTH-1:0] divisor;

    modport source (output valid, output dividend, output divisor, input ready);
    modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

interface rsd_res_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] quotient;
    logic                         divide_by_zero;
    logic                         overflowed;

    modport source (output valid, output quotient, output divide_by_zero, output overflowed,
                    input ready);
    modport sink   (input valid, input quotient, input divide_by_zero, input overflowed,
                    output ready);
endinterface

// File: rtl/rounded_signed_divider.sv
// signed divider, quotient rounded half away from zero, fully pipelined
//
// operands: sink channel carrying dividend and divisor, one beat per cycle at most
// result:   source channel carrying quotient, divide_by_zero and overflowed
// pipeline: from operand beat to result valid, one stage forms magnitudes, DATA_WIDTH
//           stages each retire one quotient bit with a DATA_WIDTH+1 bit subtract, one
//           stage rounds, one stage applies sign and saturation
// throughput: one beat per cycle while result.ready is high; every stage holds its own valid bit
// divisor zero: quotient 0 with divide_by_zero set
// most negative over minus one: quotient saturates to the maximum positive value with
//           overflowed set
// stall: when result.ready is low the output stage holds its beat; stages behind it keep
//           filling empty slots, and operands.ready drops only when every stage is full
// reset: rst_n clears all valid bits at once; the pipeline is empty and ready after it
module rounded_signed_divider
    import rsd_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    rsd_op_if.sink      operands,
    rsd_res_if.source   result
);

    localparam int NS = DATA_WIDTH + PIPE_EXTRA;
    localparam int RS = DATA_WIDTH + 1;
    localparam int OS = DATA_WIDTH + 2;
    localparam logic [DATA_WIDTH-1:0] QMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    logic [NS-1:0]         v_reg;
    logic [NS-1:0]         ld;

    logic [DATA_WIDTH-1:0] rem_reg [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] aq_reg  [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] bm_reg  [DATA_WIDTH+1];
    rsd_flag_t             flg_reg [DATA_WIDTH+1];

    logic [DATA_WIDTH-1:0] am_next;
    logic [DATA_WIDTH-1:0] bm_next;

    logic [DATA_WIDTH-1:0] qm_reg;
    logic [DATA_WIDTH-1:0] qm_next;
    rsd_flag_t             rflg_reg;
    logic                  round_up;

    logic [DATA_WIDTH-1:0] quotient_reg;
    logic [DATA_WIDTH-1:0] quotient_next;
    logic                  dz_reg;
    logic                  ovf_reg;
    logic                  ovf_next;

    // load enables, a stage takes a new beat when empty or when it moves on
    assign ld[NS-1] = !v_reg[NS-1] || result.ready;
    generate
        for (genvar s = 0; s < NS - 1; s++) begin : g_ld
            assign ld[s] = !v_reg[s] || ld[s+1];
        end
    endgenerate

    assign operands.ready = ld[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (ld[0])
            begin
                v_reg[0] <= operands.valid;
            end
            for (int s = 1; s < NS; s++)
            begin
                if (ld[s])
                begin
                    v_reg[s] <= v_reg[s-1];
                end
            end
        end
    end

    // magnitudes
    assign am_next = operands.dividend[DATA_WIDTH-1] ? (~$unsigned(operands.dividend) + 1'b1)
                                                     : $unsigned(operands.dividend);
    assign bm_next = operands.divisor[DATA_WIDTH-1] ? (~$unsigned(operands.divisor) + 1'b1)
                                                    : $unsigned(operands.divisor);

    always_ff @(posedge clk)
    begin
        if (ld[0] && operands.valid)
        begin
            rem_reg[0]     <= '0;
            aq_reg[0]      <= am_next;
            bm_reg[0]      <= bm_next;
            flg_reg[0].neg <= operands.dividend[DATA_WIDTH-1] ^ operands.divisor[DATA_WIDTH-1];
            flg_reg[0].dz  <= (bm_next == '0);
        end
    end

    // restoring divide, one quotient bit per stage
    generate
        for (genvar k = 1; k <= DATA_WIDTH; k++) begin : g_div
            logic [DATA_WIDTH:0]   shifted;
            logic [DATA_WIDTH:0]   trial;
            logic [DATA_WIDTH-1:0] rem_next;

            assign shifted  = {rem_reg[k-1], aq_reg[k-1][DATA_WIDTH-1]};
            assign trial    = shifted - {1'b0, bm_reg[k-1]};
            assign rem_next = trial[DATA_WIDTH] ? shifted[DATA_WIDTH-1:0]
                                                : trial[DATA_WIDTH-1:0];

            always_ff @(posedge clk)
            begin
                if (ld[k] && v_reg[k-1])
                begin
                    rem_reg[k] <= rem_next;
                    aq_reg[k]  <= {aq_reg[k-1][DATA_WIDTH-2:0], ~trial[DATA_WIDTH]};
                    bm_reg[k]  <= bm_reg[k-1];
                    flg_reg[k] <= flg_reg[k-1];
                end
            end
        end
    endgenerate

    // round half away from zero on the magnitude
    assign round_up = {rem_reg[DATA_WIDTH], 1'b0} >= {1'b0, bm_reg[DATA_WIDTH]};
    assign qm_next  = aq_reg[DATA_WIDTH] + {{(DATA_WIDTH-1){1'b0}}, round_up};

    always_ff @(posedge clk)
    begin
        if (ld[RS] && v_reg[RS-1])
        begin
            qm_reg   <= qm_next;
            rflg_reg <= flg_reg[DATA_WIDTH];
        end
    end

    // sign and saturation
    assign ovf_next = !rflg_reg.dz && !rflg_reg.neg && qm_reg[DATA_WIDTH-1];

    always_comb
    begin
        priority if (rflg_reg.dz)
        begin
            quotient_next = '0;
        end
        else if (ovf_next)
        begin
            quotient_next = QMAX;
        end
        else if (rflg_reg.neg)
        begin
            quotient_next = ~qm_reg + 1'b1;
        end
        else
        begin
            quotient_next = qm_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[OS] && v_reg[OS-1])
        begin
            quotient_reg <= quotient_next;
            dz_reg       <= rflg_reg.dz;
            ovf_reg      <= ovf_next;
        end
    end

    assign result.valid          = v_reg[NS-1];
    assign result.quotient       = $signed(quotient_reg);
    assign result.divide_by_zero = dz_reg;
    assign result.overflowed     = ovf_reg;

endmodule

// File: rtl/rsd_checker.sv
// port-level checks for the rounded signed divider, bound to the top level
module rsd_checker #(
    parameter int DATA_WIDTH = 32
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  res_valid,
    input logic                  res_ready,
    input logic [DATA_WIDTH-1:0] res_quotient,
    input logic                  res_dz,
    input logic                  res_ovf
);

    localparam logic [DATA_WIDTH-1:0] QMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    // stalled result beat holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_quotient)
                                    && $stable(res_dz) && $stable(res_ovf))
        else $error("result beat changed while stalled");

    // flags exclude each other
    a_flag_excl: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res_dz && res_ovf))
        else $error("divide_by_zero and overflowed both set");

    // divide by zero gives zero
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_dz |-> res_quotient == '0)
        else $error("nonzero quotient on divide by zero");

    // overflow saturates
    a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ovf |-> res_quotient == QMAX)
        else $error("overflow not saturated to maximum");

endmodule

bind rounded_signed_divider rsd_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_rsd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .res_quotient (result.quotient),
    .res_dz       (result.divide_by_zero),
    .res_ovf      (result.overflowed)
);
